/* design/fvpl_pkg.sv */
// Shared types and constants of the first-valley parabolic locator.
package fvpl_pkg;

  localparam int SMP_W = 24;
  localparam int SQ_W  = 48;
  localparam int VAL_W = 22;
  localparam int CFG_W = 32;
  localparam int NUM_W = 54;
  localparam int DEN_W = 24;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CENTER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH    = 1'b1;

  localparam logic [CFG_W-1:0] FIRST_CENTER_RST = 32'd83886;
  localparam logic [CFG_W-1:0] BIN_WIDTH_RST    = 32'd83047;

  localparam logic [SQ_W-1:0]  THREE_Q40 = 48'h0300_0000_0000;
  localparam logic [VAL_W-1:0] ONE_Q20   = 22'h10_0000;

  typedef struct packed {
    logic load;
    logic eval;
    logic vtx;
    logic div_start;
    logic fin;
    logic sat;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
    logic den_zero;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

/* design/first_valley_parabolic_locator.sv */
// Top level of the first-valley parabolic locator.
// Each accepted bin is evaluated, and no new bin is accepted until the previous
// one is through. The bin that locates the valley adds vertex setup plus the serial
// divider over 54 quotient bits, or only the setup when the denominator is zero.
// The bin marked last adds the EMIT state, which loads the result register and
// waits while an earlier result is untaken.
// Reset (rst_ni low, asynchronous) clears the scan state and the result valid,
// and restores both configuration registers to their defaults.
module first_valley_parabolic_locator #(
  parameter int MAX_BINS = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [fvpl_pkg::SMP_W-1:0] gen_re_i,
  input  logic signed [fvpl_pkg::SMP_W-1:0] gen_im_i,
  input  logic                           last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [31:0]             radius_o,
  output logic                           found_o,
  input  logic                           cfg_we_i,
  input  logic [fvpl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fvpl_pkg::CFG_W-1:0]     cfg_data_i
);

  // The controller and datapath talk only through these two bundles.
  fvpl_pkg::cmd_t    cmd;
  fvpl_pkg::status_t sts;

  // The controller walks each transaction through evaluation and, on the valley
  // bin, through the vertex computation and, unless the denominator is zero, the division.
  fvpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the window of three bin values, the bin counter, the
  // located vertex and the output register. The output register lets the
  // next scan start while a finished result still waits to be taken.
  fvpl_datapath #(
    .MAX_BINS (MAX_BINS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .gen_re_i    (gen_re_i),
    .gen_im_i    (gen_im_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .radius_o    (radius_o),
    .found_o     (found_o)
  );

  // A result that reports no valley always carries a zero radius.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> radius_o == '0)
    else $error("nonzero radius without a valley");

endmodule

/* design/fvpl_div.sv */
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
module fvpl_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fvpl_pkg::NUM_W-1:0] dividend_i,
  input  logic [fvpl_pkg::DEN_W-1:0] divisor_i,
  output logic [fvpl_pkg::NUM_W-1:0] quot_o,
  output logic                       done_o
);

  localparam int NW = fvpl_pkg::NUM_W;
  localparam int DW = fvpl_pkg::DEN_W;
  localparam int CW = $clog2(NW);

  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] div_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [DW:0]   trial;
  logic          take;

  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    take  = trial >= {1'b0, div_q};
    rem_d = take ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
    quo_d = {quo_q[NW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

  // A new division must never be started while one is still running.
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");

endmodule

/* design/fvpl_datapath.sv */
// Datapath: modulus squared, valley window, vertex arithmetic and result register.
module fvpl_datapath #(
  parameter int MAX_BINS = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fvpl_pkg::cmd_t                 cmd_i,
  output fvpl_pkg::status_t              sts_o,
  input  logic                           cfg_we_i,
  input  logic [fvpl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fvpl_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic signed [fvpl_pkg::SMP_W-1:0] gen_re_i,
  input  logic signed [fvpl_pkg::SMP_W-1:0] gen_im_i,
  input  logic                           last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [31:0]             radius_o,
  output logic                           found_o
);

  localparam int CNT_W = $clog2(MAX_BINS + 1);
  localparam int X0_W  = fvpl_pkg::CFG_W + CNT_W + 1;
  localparam int NW    = fvpl_pkg::NUM_W;
  localparam int VW    = fvpl_pkg::VAL_W;
  localparam int R_W   = ((X0_W > NW) ? X0_W : NW) + 2;
  localparam logic signed [R_W-1:0] SAT_MAX = {{(R_W-32){1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [R_W-1:0] SAT_MIN = {{(R_W-32){1'b1}}, 32'h8000_0000};

  logic [fvpl_pkg::CFG_W-1:0] fc_q, bw_q;
  logic [fvpl_pkg::SQ_W-1:0]  sq_re_q, sq_im_q;
  logic                       last_q;
  logic [VW-1:0]              win0_q, win1_q, win2_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       found_q;
  logic [31:0]                radius_q;
  logic [VW-1:0]              hl_q, h0_q, hn_q;
  logic [CNT_W-1:0]           bidx_q;
  logic [NW-1:0]              num_q;
  logic [fvpl_pkg::DEN_W-1:0] den_q;
  logic                       neg_q;
  logic [X0_W-1:0]            x0_q;
  logic signed [R_W-1:0]      r_q;
  logic                       out_valid_q;
  logic signed [31:0]         radius_out_q;
  logic                       found_out_q;

  logic [fvpl_pkg::SQ_W:0]    sum;
  logic [VW-1:0]              cur;
  logic                       can_shift;
  logic                       hit;
  logic signed [VW:0]         dif;
  logic [VW-1:0]              dif_mag;
  logic signed [VW+2:0]       d0;
  logic [VW:0]                d0_mag;
  logic [NW-1:0]              quot;
  logic                       div_done;
  logic [fvpl_pkg::CFG_W+CNT_W-1:0] step_prod;
  logic signed [R_W-1:0]      q_signed;

  // Bin test: the new sample plays the part of the bin two after the candidate.
  always_comb begin
    sum       = {1'b0, sq_re_q} + {1'b0, sq_im_q};
    cur       = (sum > {1'b0, fvpl_pkg::THREE_Q40}) ? '0 : sum[VW+19:20];
    can_shift = cnt_q < CNT_W'(MAX_BINS);
    hit       = can_shift && (cnt_q >= CNT_W'(3)) && !found_q &&
                (win0_q > win1_q) && (cur > win1_q) && (win1_q < fvpl_pkg::ONE_Q20);
  end

  always_comb begin
    dif     = $signed({1'b0, hl_q}) - $signed({1'b0, hn_q});
    dif_mag = dif[VW] ? VW'(-dif) : dif[VW-1:0];
    d0      = $signed({2'b00, h0_q, 1'b0}) - $signed({3'b000, hn_q})
              - $signed({3'b000, hl_q});
    d0_mag  = d0[VW+2] ? (VW+1)'(-d0) : d0[VW:0];
    step_prod = bw_q * bidx_q;
    q_signed  = neg_q ? -$signed({{(R_W-NW){1'b0}}, quot})
                      :  $signed({{(R_W-NW){1'b0}}, quot});
  end

  fvpl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (num_q),
    .divisor_i  (den_q),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q         <= fvpl_pkg::FIRST_CENTER_RST;
      bw_q         <= fvpl_pkg::BIN_WIDTH_RST;
      win0_q       <= '0;
      win1_q       <= '0;
      win2_q       <= '0;
      cnt_q        <= '0;
      found_q      <= 1'b0;
      radius_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fvpl_pkg::CFG_FIRST_CENTER: fc_q <= cfg_data_i;
          fvpl_pkg::CFG_BIN_WIDTH:    bw_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.eval) begin
        if (hit) begin
          found_q <= 1'b1;
        end
        if (can_shift) begin
          win2_q <= win1_q;
          win1_q <= win0_q;
          win0_q <= cur;
          cnt_q  <= cnt_q + 1'b1;
        end
      end
      if (cmd_i.sat) begin
        if (r_q > SAT_MAX) begin
          radius_q <= SAT_MAX[31:0];
        end else if (r_q < SAT_MIN) begin
          radius_q <= SAT_MIN[31:0];
        end else begin
          radius_q <= r_q[31:0];
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        win0_q      <= '0;
        win1_q      <= '0;
        win2_q      <= '0;
        cnt_q       <= '0;
        found_q     <= 1'b0;
        radius_q    <= '0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sq_re_q <= fvpl_pkg::SQ_W'(gen_re_i * gen_re_i);
      sq_im_q <= fvpl_pkg::SQ_W'(gen_im_i * gen_im_i);
      last_q  <= last_i;
    end
    if (cmd_i.eval && hit) begin
      hl_q   <= win2_q;
      h0_q   <= win1_q;
      hn_q   <= win0_q;
      bidx_q <= cnt_q - CNT_W'(2);
    end
    if (cmd_i.vtx) begin
      num_q <= bw_q * dif_mag;
      den_q <= {d0_mag, 1'b0};
      neg_q <= dif[VW] ^ d0[VW+2];
      x0_q  <= {{(CNT_W+1){1'b0}}, fc_q} + {1'b0, step_prod};
    end
    if (cmd_i.fin) begin
      r_q <= $signed({{(R_W-X0_W){1'b0}}, x0_q}) - (sts_o.den_zero ? '0 : q_signed);
    end
    if (cmd_i.emit) begin
      radius_out_q <= found_q ? $signed(radius_q) : '0;
      found_out_q  <= found_q;
    end
  end

  always_comb begin
    sts_o.hit      = hit;
    sts_o.last     = last_q;
    sts_o.den_zero = (d0 == '0);
    sts_o.div_done = div_done;
    sts_o.out_busy = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign radius_o    = radius_out_q;
  assign found_o     = found_out_q;

  // The bin count saturates at the scan limit and never runs past it.
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_BINS)) else $error("bin count beyond limit");

endmodule

/* design/fvpl_ctrl.sv */
// Controller state machine that sequences the locator datapath.
module fvpl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fvpl_pkg::status_t sts_i,
  output fvpl_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    IDLE,
    EVAL,
    VTX,
    DIV_GO,
    DIV_WAIT,
    FIN,
    SAT,
    EMIT
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
    end else begin
      case (state_q)
        IDLE: begin
          if (in_valid_i) state_q <= EVAL;
        end
        EVAL: begin
          if (sts_i.hit) state_q <= VTX;
          else if (sts_i.last) state_q <= EMIT;
          else state_q <= IDLE;
        end
        VTX: begin
          state_q <= sts_i.den_zero ? FIN : DIV_GO;
        end
        DIV_GO: begin
          state_q <= DIV_WAIT;
        end
        DIV_WAIT: begin
          if (sts_i.div_done) state_q <= FIN;
        end
        FIN: begin
          state_q <= SAT;
        end
        SAT: begin
          state_q <= sts_i.last ? EMIT : IDLE;
        end
        EMIT: begin
          if (!sts_i.out_busy) state_q <= IDLE;
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == IDLE) && in_valid_i;
    cmd_o.eval      = (state_q == EVAL);
    cmd_o.vtx       = (state_q == VTX);
    cmd_o.div_start = (state_q == DIV_GO);
    cmd_o.fin       = (state_q == FIN);
    cmd_o.sat       = (state_q == SAT);
    cmd_o.emit      = (state_q == EMIT) && !sts_i.out_busy;
  end

  assign in_ready_o = (state_q == IDLE);

  // An accepted sample is evaluated in the very next cycle.
  a_load_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == IDLE && in_valid_i) |=> state_q == EVAL)
    else $error("accepted sample not evaluated");

  // The divider is only waited on when the denominator is nonzero.
  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == DIV_WAIT |-> !sts_i.den_zero)
    else $error("division with zero denominator");

endmodule
